FILE: hdl/khrt_pkg.sv
// Shared types and constants for the keypad hold and repeat tracker.
package khrt_pkg;

  localparam int NUM_KEYS = 10;
  localparam int HOLD_W   = 6;
  localparam int REL_W    = 8;

  typedef logic [NUM_KEYS-1:0] keys_t;
  typedef logic [HOLD_W-1:0]   hold_t;
  typedef logic [REL_W-1:0]    rel_t;
  typedef logic [1:0]          action_t;
  typedef logic [3:0]          key_idx_t;

  // Request actions.
  localparam action_t ACT_TICK  = 2'd0;
  localparam action_t ACT_DIR   = 2'd1;
  localparam action_t ACT_PAIR  = 2'd2;
  localparam action_t ACT_CLEAR = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_PAIR_TRIG = 1'b0;
  localparam logic CFG_DIR_TRIG  = 1'b1;

  localparam hold_t TRIG_PAIR_RESET = 6'd5;
  localparam hold_t TRIG_DIR_RESET  = 6'd10;

  localparam hold_t HOLD_ONE      = 6'd1;
  localparam hold_t HOLD_TOP      = 6'd32;
  localparam hold_t HOLD_FALLBACK = 6'd29;
  localparam rel_t  RELEASE_MAX   = 8'd255;
  localparam rel_t  RELEASE_FIRE  = 8'd1;
  localparam rel_t  RELEASE_UNLATCH = 8'd2;

  // Direction keys in handheld bit order.
  localparam keys_t MASK_RIGHT = 10'b00_0001_0000;
  localparam keys_t MASK_LEFT  = 10'b00_0010_0000;
  localparam keys_t MASK_UP    = 10'b00_0100_0000;
  localparam keys_t MASK_DOWN  = 10'b00_1000_0000;

  typedef struct packed {
    keys_t                          held;
    keys_t                          pressed;
    keys_t                          rpt;
    keys_t                          latch;
    logic [NUM_KEYS-1:0][HOLD_W-1:0] hold_cnt;
    logic [NUM_KEYS-1:0][REL_W-1:0]  rel_cnt;
  } state_t;

  typedef struct packed {
    keys_t held_mask;
    keys_t pressed_mask;
    keys_t repeat_mask;
    keys_t event_mask;
    hold_t hold_time_a;
    rel_t  release_time_a;
  } result_t;

  localparam state_t STATE_RESET = '{
    held:     '0,
    pressed:  '0,
    rpt:      '0,
    latch:    '0,
    hold_cnt: '0,
    rel_cnt:  {NUM_KEYS{RELEASE_MAX}}
  };

endpackage

FILE: hdl/keypad_hold_repeat_tracker.sv
// Keypad hold and repeat tracker top level: state, trigger registers and result register.
// The result of an accepted request is registered and shows on the outputs at the next edge.
// Throughput: one request per cycle while the result register is empty or being drained;
// all ten per-key counter lanes update in one pass. A stalled result holds in the output
// register; a new request is taken whenever the result register is empty or being drained in the same cycle.
// Reset (synchronous, active low) clears all key state, sets release counters to 255,
// restores the trigger registers to 5 and 10 and empties the result register.
module keypad_hold_repeat_tracker import khrt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  action_t  in_action,
  input  keys_t    in_raw_keys,
  input  key_idx_t in_key_a,
  input  key_idx_t in_key_b,
  output logic     out_valid,
  input  logic     out_ready,
  output keys_t    out_held_mask,
  output keys_t    out_pressed_mask,
  output keys_t    out_repeat_mask,
  output keys_t    out_event_mask,
  output hold_t    out_hold_time_a,
  output rel_t     out_release_time_a,
  input  logic     cfg_we,
  input  logic     cfg_index,
  input  hold_t    cfg_wdata
);

  state_t  st_r;
  state_t  st_nxt;
  result_t res_nxt;
  result_t res_r;
  hold_t   pair_trig_r;
  hold_t   dir_trig_r;
  logic    out_valid_r;
  logic    in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  khrt_step u_step (
    .action    (in_action),
    .raw_keys  (in_raw_keys),
    .key_a     (in_key_a),
    .key_b     (in_key_b),
    .pair_trig (pair_trig_r),
    .dir_trig  (dir_trig_r),
    .st        (st_r),
    .st_nxt    (st_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= STATE_RESET;
      pair_trig_r <= TRIG_PAIR_RESET;
      dir_trig_r  <= TRIG_DIR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PAIR_TRIG: pair_trig_r <= cfg_wdata;
          default:       dir_trig_r  <= cfg_wdata;
        endcase
      end
      if (in_fire) begin
        st_r <= st_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_held_mask      = res_r.held_mask;
  assign out_pressed_mask   = res_r.pressed_mask;
  assign out_repeat_mask    = res_r.repeat_mask;
  assign out_event_mask     = res_r.event_mask;
  assign out_hold_time_a    = res_r.hold_time_a;
  assign out_release_time_a = res_r.release_time_a;

endmodule

FILE: hdl/khrt_step.sv
// Next-state and result logic for one request of the keypad tracker.
module khrt_step import khrt_pkg::*; (
  input  action_t  action,
  input  keys_t    raw_keys,
  input  key_idx_t key_a,
  input  key_idx_t key_b,
  input  hold_t    pair_trig,
  input  hold_t    dir_trig,
  input  state_t   st,
  output state_t   st_nxt,
  output result_t  res
);

  // One of the two keys newly pressed while the other is held.
  function automatic logic combo(keys_t pressed, keys_t held, keys_t ma, keys_t mb);
    combo = ((|(pressed & ma)) && (|(held & mb))) ||
            ((|(pressed & mb)) && (|(held & ma)));
  endfunction

  keys_t keys;
  keys_t ma;
  keys_t mb;
  keys_t rel_unlatch;
  keys_t fire_pair;
  keys_t fire_dir;
  state_t tick_st;
  keys_t latch_w;
  keys_t ev;
  hold_t hold_a;
  rel_t  rel_a;

  assign keys = ~raw_keys;

  // Per-key lanes: decoders, flags and the tick update.
  always_comb begin
    tick_st = st;
    tick_st.pressed = keys & ~st.held;
    tick_st.held = keys;
    for (int i = 0; i < NUM_KEYS; i++) begin
      ma[i] = (key_a == key_idx_t'(i));
      mb[i] = (key_b == key_idx_t'(i));
      rel_unlatch[i] = (st.rel_cnt[i] == RELEASE_UNLATCH);
      fire_pair[i] = (st.hold_cnt[i] == pair_trig) || (st.rel_cnt[i] == RELEASE_FIRE);
      fire_dir[i] = (st.hold_cnt[i] == dir_trig) || (st.rel_cnt[i] == RELEASE_FIRE);
      if (keys[i]) begin
        if (st.hold_cnt[i] >= HOLD_TOP) begin
          tick_st.hold_cnt[i] = HOLD_FALLBACK;
        end else begin
          tick_st.hold_cnt[i] = st.hold_cnt[i] + HOLD_ONE;
        end
        tick_st.rel_cnt[i] = '0;
      end else begin
        tick_st.hold_cnt[i] = '0;
        if (st.rel_cnt[i] != RELEASE_MAX) begin
          tick_st.rel_cnt[i] = st.rel_cnt[i] + RELEASE_FIRE;
        end
      end
      tick_st.rpt[i] = (tick_st.hold_cnt[i] == HOLD_ONE) ||
                       (tick_st.hold_cnt[i] == HOLD_TOP);
    end
  end

  // Action evaluation: tick update, clear, or a direction or pair poll in which later matches overwrite earlier ones.
  always_comb begin
    st_nxt = st;
    latch_w = st.latch;
    ev = '0;
    case (action)
      ACT_TICK: begin
        st_nxt = tick_st;
      end
      ACT_DIR: begin
        latch_w = latch_w & ~(rel_unlatch & (MASK_UP | MASK_DOWN | MASK_LEFT | MASK_RIGHT));
        if (combo(st.pressed, st.held, MASK_UP, MASK_LEFT)) begin
          latch_w = latch_w | MASK_UP | MASK_LEFT;
          ev = MASK_UP | MASK_LEFT;
        end
        if (combo(st.pressed, st.held, MASK_UP, MASK_RIGHT)) begin
          latch_w = latch_w | MASK_UP | MASK_RIGHT;
          ev = MASK_UP | MASK_RIGHT;
        end
        if (combo(st.pressed, st.held, MASK_DOWN, MASK_LEFT)) begin
          latch_w = latch_w | MASK_DOWN | MASK_LEFT;
          ev = MASK_DOWN | MASK_LEFT;
        end
        if (combo(st.pressed, st.held, MASK_DOWN, MASK_RIGHT)) begin
          latch_w = latch_w | MASK_DOWN | MASK_RIGHT;
          ev = MASK_DOWN | MASK_RIGHT;
        end
        if (!(|(latch_w & MASK_UP)) && (|(fire_dir & MASK_UP))) begin
          latch_w = latch_w | MASK_UP;
          ev = MASK_UP;
        end
        if (!(|(latch_w & MASK_DOWN)) && (|(fire_dir & MASK_DOWN))) begin
          latch_w = latch_w | MASK_DOWN;
          ev = MASK_DOWN;
        end
        if (!(|(latch_w & MASK_LEFT)) && (|(fire_dir & MASK_LEFT))) begin
          latch_w = latch_w | MASK_LEFT;
          ev = MASK_LEFT;
        end
        if (!(|(latch_w & MASK_RIGHT)) && (|(fire_dir & MASK_RIGHT))) begin
          latch_w = latch_w | MASK_RIGHT;
          ev = MASK_RIGHT;
        end
        st_nxt.latch = latch_w;
      end
      ACT_PAIR: begin
        // Out-of-range indexes decode to an empty mask and take no part.
        latch_w = latch_w & ~(rel_unlatch & (ma | mb));
        if (combo(st.pressed, st.held, ma, mb)) begin
          latch_w = latch_w | ma | mb;
          ev = ma | mb;
        end
        if (!(|(latch_w & ma)) && (|(fire_pair & ma))) begin
          latch_w = latch_w | ma;
          ev = ma;
        end
        if (!(|(latch_w & mb)) && (|(fire_pair & mb))) begin
          latch_w = latch_w | mb;
          ev = mb;
        end
        st_nxt.latch = latch_w;
      end
      default: begin
        st_nxt = STATE_RESET;
      end
    endcase
  end

  // Counters of key_a after the update; zero for an out-of-range index.
  always_comb begin
    hold_a = '0;
    rel_a = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (ma[i]) begin
        hold_a = hold_a | st_nxt.hold_cnt[i];
        rel_a = rel_a | st_nxt.rel_cnt[i];
      end
    end
  end

  assign res.held_mask      = st_nxt.held;
  assign res.pressed_mask   = st_nxt.pressed;
  assign res.repeat_mask    = st_nxt.rpt;
  assign res.event_mask     = ev;
  assign res.hold_time_a    = hold_a;
  assign res.release_time_a = rel_a;

endmodule

FILE: hdl/khrt_checker.sv
// Port-level checks for the keypad hold and repeat tracker, bound to the top level.
module khrt_checker import khrt_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_ready,
  input keys_t    out_held_mask,
  input keys_t    out_pressed_mask,
  input keys_t    out_repeat_mask,
  input keys_t    out_event_mask,
  input hold_t    out_hold_time_a,
  input rel_t     out_release_time_a
);

  // A newly pressed key is always among the held keys.
  a_pressed_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pressed_mask & ~out_held_mask) == '0)
    else $error("pressed key not held");

  // A repeat can only come from a held key.
  a_repeat_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_repeat_mask & ~out_held_mask) == '0)
    else $error("repeat on released key");

  // A held key has a running hold count and a zero release count.
  a_hold_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hold_time_a != '0) |->
      (out_release_time_a == '0 && out_hold_time_a <= HOLD_TOP))
    else $error("hold and release counters disagree");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_event_mask) && $stable(out_held_mask)))
    else $error("stalled result changed");

endmodule

bind keypad_hold_repeat_tracker khrt_checker u_khrt_checker (.*);
